// ===== src/sha1s_pkg.sv =====
// Shared types and constants of the streaming SHA-1 hasher.
`timescale 1ns / 1ps

package sha1s_pkg;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// How the back must treat a queued word.
	typedef enum logic [1:0] {
		KIND_DATA,   // ordinary message word
		KIND_FULL,   // last word with four bytes, marker goes into the next word
		KIND_PART    // last word with the marker already merged in
	} kind_t;

	// One queued item: the word to store, its kind and the message length so far.
	typedef struct packed {
		logic [31:0] word;
		kind_t       kind;
		logic [63:0] bit_len;
	} q_entry_t;

endpackage

// ===== src/sha1s_front.sv =====
// Front end: accepts message words, tracks the bit length and places the pad marker.
`timescale 1ns / 1ps

module sha1s_front
	import sha1s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	input  logic        q_full,
	output logic        q_push,
	output q_entry_t    q_entry
);

	logic [63:0] bit_len_q;
	logic [2:0]  sat_count;
	logic [63:0] len_next;

	assign data_stall = q_full;
	assign q_push     = data_valid && !q_full;

	// A last word counts at most four bytes; any other word always counts four.
	always_comb begin
		if (!last_word) begin
			sat_count = 3'd4;
		end else if (byte_count > 3'd4) begin
			sat_count = 3'd4;
		end else begin
			sat_count = byte_count;
		end
		len_next = bit_len_q + {58'd0, sat_count, 3'd0};
	end

	// Classify the item and merge the 0x80 marker behind the valid bytes.
	always_comb begin
		q_entry.bit_len = len_next;
		q_entry.word    = data_word;
		q_entry.kind    = KIND_DATA;
		if (last_word) begin
			q_entry.kind = KIND_PART;
			case (sat_count)
				3'd0:    q_entry.word = 32'h8000_0000;
				3'd1:    q_entry.word = {data_word[31:24], 24'h80_0000};
				3'd2:    q_entry.word = {data_word[31:16], 16'h8000};
				3'd3:    q_entry.word = {data_word[31:8], 8'h80};
				default: q_entry.kind = KIND_FULL;
			endcase
		end
	end

	// The length restarts after each message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_len_q <= '0;
		end else if (q_push) begin
			bit_len_q <= last_word ? 64'd0 : len_next;
		end
	end

endmodule

// ===== src/sha1s_queue.sv =====
// Short first-in first-out queue between the front and the back.
`timescale 1ns / 1ps

module sha1s_queue
	import sha1s_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     full,
	input  logic     pop,
	output logic     pop_valid,
	output q_entry_t pop_entry
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	q_entry_t          mem_q [Depth];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == CNT_W'(Depth));
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("Queue read while empty.");

endmodule

// ===== src/sha1s_back.sv =====
// Back end: block buffer, padding sequencer, 80-round compression and digest output.
`timescale 1ns / 1ps

module sha1s_back
	import sha1s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  q_entry_t    q_entry,
	output logic        q_pop,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_digest_word
);

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};
	localparam logic [31:0] K_0      = 32'h5A827999;
	localparam logic [31:0] K_1      = 32'h6ED9EBA1;
	localparam logic [31:0] K_2      = 32'h8F1BBCDC;
	localparam logic [31:0] K_3      = 32'hCA62C1D6;
	localparam logic [31:0] MARK     = 32'h8000_0000;
	localparam logic [3:0]  LEN_SLOT = 4'd14;
	localparam logic [3:0]  LAST_POS = 4'd15;
	localparam logic [6:0]  LAST_RND = 7'd79;
	localparam logic [2:0]  LAST_IDX = 3'd4;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PAD_IDLE,
		PAD_MARK,
		PAD_FILL,
		PAD_LEN_LO,
		PAD_DONE
	} pad_t;

	state_t      state_q;
	pad_t        pad_q;
	pad_t        pad_next;
	logic [31:0] win_q [16];
	logic [31:0] chain_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [3:0]  pos_q;
	logic [6:0]  round_q;
	logic [2:0]  idx_q;
	logic [63:0] len_q;

	logic        push_en;
	logic [31:0] push_word;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] sched_new;

	// Take a queued item only when no padding is pending.
	assign q_pop   = (state_q == ST_LOAD) && (pad_q == PAD_IDLE) && q_valid;
	assign push_en = q_pop || ((state_q == ST_LOAD) && (pad_q != PAD_IDLE)
		&& (pad_q != PAD_DONE));

	// Word source and next padding step.
	always_comb begin
		push_word = '0;
		pad_next  = pad_q;
		if (q_pop) begin
			push_word = q_entry.word;
			unique case (q_entry.kind)
				KIND_FULL: pad_next = PAD_MARK;
				KIND_PART: pad_next = PAD_FILL;
				default:   pad_next = PAD_IDLE;
			endcase
		end else begin
			unique case (pad_q)
				PAD_MARK: begin
					push_word = MARK;
					pad_next  = PAD_FILL;
				end
				PAD_FILL: begin
					if (pos_q == LEN_SLOT) begin
						push_word = len_q[63:32];
						pad_next  = PAD_LEN_LO;
					end
				end
				PAD_LEN_LO: begin
					push_word = len_q[31:0];
					pad_next  = PAD_DONE;
				end
				default: pad_next = pad_q;
			endcase
		end
	end

	// Round function, constant and schedule expansion.
	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_3;
		end
		t_val     = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + win_q[0];
		sched_new = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		sched_new = {sched_new[30:0], sched_new[31]};
	end

	// The schedule window holds the block while filling, then slides one word a round.
	always_ff @(posedge clk) begin
		if (push_en) begin
			win_q[pos_q] <= push_word;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= sched_new;
		end
		if (q_pop) begin
			len_q <= q_entry.bit_len;
		end
	end

	// Sequencer, chaining words and working variables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pad_q   <= PAD_IDLE;
			pos_q   <= '0;
			round_q <= '0;
			idx_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			e_q     <= '0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= H_INIT[i];
			end
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (push_en) begin
						pad_q <= pad_next;
						pos_q <= pos_q + 1'b1;
						if (pos_q == LAST_POS) begin
							state_q <= ST_ROUND;
							round_q <= '0;
							a_q     <= chain_q[0];
							b_q     <= chain_q[1];
							c_q     <= chain_q[2];
							d_q     <= chain_q[3];
							e_q     <= chain_q[4];
						end
					end
				end
				ST_ROUND: begin
					a_q     <= t_val;
					b_q     <= a_q;
					c_q     <= {b_q[1:0], b_q[31:2]};
					d_q     <= c_q;
					e_q     <= d_q;
					round_q <= round_q + 1'b1;
					if (round_q == LAST_RND) begin
						chain_q[0] <= chain_q[0] + t_val;
						chain_q[1] <= chain_q[1] + a_q;
						chain_q[2] <= chain_q[2] + {b_q[1:0], b_q[31:2]};
						chain_q[3] <= chain_q[3] + c_q;
						chain_q[4] <= chain_q[4] + d_q;
						state_q    <= (pad_q == PAD_DONE) ? ST_OUT : ST_LOAD;
						idx_q      <= '0;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							pad_q   <= PAD_IDLE;
							state_q <= ST_LOAD;
							for (int i = 0; i < 5; i++) begin
								chain_q[i] <= H_INIT[i];
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Digest words are read straight from the chaining registers.
	assign digest_valid     = (state_q == ST_OUT);
	assign digest_word      = chain_q[idx_q];
	assign word_index       = idx_q;
	assign last_digest_word = (idx_q == LAST_IDX);

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= LAST_RND))
		else $error("Round counter ran past the last round.");

	a_digest_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (pos_q == 4'd0 && pad_q == PAD_DONE))
		else $error("Digest shown before the final block was absorbed.");

endmodule

// ===== src/sha1_stream_hasher.sv =====
// Top level of the streaming SHA-1 hasher.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  message  | data_valid / data_stall    | data_word[31:0], byte_count[2:0], last_word
//  digest   | digest_valid / digest_stall| digest_word[31:0], word_index[2:0],
//           |                            | last_digest_word
//
// A message word is written into the queue when accepted; the back stores one word per cycle
// while it loads a block and compresses each 16-word block one round per cycle.
// The last word adds up to 18 padding words and one or two compressions,
// then the five digest words leave one per cycle while digest_stall is low.
// Reset is asynchronous and active low; the hasher is ready right after it.
// The front stalls only when the queue is full; the back holds the digest while stalled.
`timescale 1ns / 1ps

module sha1_stream_hasher
	import sha1s_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_digest_word
);

	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_valid;
	q_entry_t push_entry;
	q_entry_t pop_entry;

	sha1s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry)
	);

	sha1s_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (pop_entry)
	);

	sha1s_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_entry          (pop_entry),
		.q_pop            (q_pop),
		.digest_valid     (digest_valid),
		.digest_stall     (digest_stall),
		.digest_word      (digest_word),
		.word_index       (word_index),
		.last_digest_word (last_digest_word)
	);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the streaming SHA-1 hasher.
`timescale 1ns / 1ps

module tb;

	// Cycles without any accepted item before the run is declared hung.
	localparam int STALL_LIMIT = 5000;
	// Cycles the digest receiver holds off during the back-pressure test.
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 440;
	localparam int DRAIN_CYCLES = 60;
	localparam int DIRECTED_ROWS = 12;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
	localparam logic [31:0] K_CHOOSE = 32'h5A827999;
	localparam logic [31:0] K_PARITY_LO = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
	localparam logic [31:0] K_PARITY_HI = 32'hCA62C1D6;
	localparam logic [31:0] PAD_MARKER = 32'h80;
	localparam logic [3:0] LENGTH_SLOT = 4'd14;

	// One directed stimulus row; known marks a row whose digest is typed in.
	typedef struct packed {
		logic [31:0]  word;
		logic [2:0]   count;
		logic         last;
		logic         known;
		logic [159:0] digest;
	} stim_row_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_exp_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Empty message, with junk in the unused bytes.
		'{32'hFFFFFFFF, 3'd0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
		// The three-byte message "abc", with a junk fourth byte.
		'{32'h616263A5, 3'd3, 1'b1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
		// Non-last words with short and oversized counts are taken as full words.
		'{32'h00000000, 3'd4, 1'b0, 1'b0, 160'd0},
		'{32'hFFFFFFFF, 3'd0, 1'b0, 1'b0, 160'd0},
		'{32'h12345678, 3'd7, 1'b0, 1'b0, 160'd0},
		// Last words with oversized (saturated to four bytes), full, short and empty counts.
		'{32'hDEADBEEF, 3'd7, 1'b1, 1'b0, 160'd0},
		'{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, 160'd0},
		'{32'hA5A5A5A5, 3'd5, 1'b1, 1'b0, 160'd0},
		'{32'h5A5A5A5A, 3'd6, 1'b1, 1'b0, 160'd0},
		'{32'hFFFFFFFF, 3'd1, 1'b1, 1'b0, 160'd0},
		'{32'hFFFFFFFF, 3'd2, 1'b1, 1'b0, 160'd0},
		'{32'h00000000, 3'd0, 1'b1, 1'b0, 160'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        data_valid;
	logic        data_stall;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_word;
	logic        digest_valid;
	logic        digest_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_digest_word;

	// Predictor state.
	logic [31:0] hash_state [5];
	logic [31:0] msg_block [16];
	logic [63:0] msg_bits;
	logic [3:0]  block_fill;
	digest_exp_t digest_expected [$];

	int mismatch_count = 0;
	int items_sent;
	int idle_cycles = 0;
	logic quiet;
	logic hold_req;

	sha1_stream_hasher u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_valid       (data_valid),
		.data_stall       (data_stall),
		.data_word        (data_word),
		.byte_count       (byte_count),
		.last_word        (last_word),
		.digest_valid     (digest_valid),
		.digest_stall     (digest_stall),
		.digest_word      (digest_word),
		.word_index       (word_index),
		.last_digest_word (last_digest_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic sha1_reset_chain();
		hash_state[0] = H0_INIT;
		hash_state[1] = H1_INIT;
		hash_state[2] = H2_INIT;
		hash_state[3] = H3_INIT;
		hash_state[4] = H4_INIT;
		msg_bits = '0;
		block_fill = '0;
	endtask

	// Eighty rounds over the expanded schedule of the current block.
	task automatic sha1_compress();
		logic [31:0] sched [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			sched[i] = msg_block[i];
		for (int i = 16; i < 80; i++)
			sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_CHOOSE;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PARITY_LO;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJORITY;
			end else begin
				f = b ^ c ^ d;
				k = K_PARITY_HI;
			end
			t = rotl(a, 5) + f + e + k + sched[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endtask

	task automatic sha1_store(input logic [31:0] w);
		msg_block[block_fill] = w;
		block_fill = block_fill + 4'd1;
		if (block_fill == 4'd0)
			sha1_compress();
	endtask

	// Advances the predictor by one accepted item and queues any digest words.
	task automatic sha1_absorb(input stim_row_t row);
		logic [31:0] mask;
		logic [159:0] result;
		int n;
		digest_exp_t exp_word;
		if (!row.last) begin
			msg_bits += 64'd32;
			sha1_store(row.word);
		end else begin
			n = (row.count > 3'd4) ? 4 : int'(row.count);
			msg_bits += 64'(8 * n);
			if (n == 4) begin
				sha1_store(row.word);
				sha1_store(PAD_MARKER << 24);
			end else begin
				mask = (n == 0) ? 32'd0 : (32'hFFFFFFFF << (32 - 8 * n));
				sha1_store((row.word & mask) | (PAD_MARKER << (24 - 8 * n)));
			end
			while (block_fill != LENGTH_SLOT)
				sha1_store(32'd0);
			sha1_store(msg_bits[63:32]);
			sha1_store(msg_bits[31:0]);
			result = row.known ? row.digest :
				{hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
			for (int i = 0; i < 5; i++) begin
				exp_word.word = result[159 - 32 * i -: 32];
				exp_word.index = 3'(i);
				exp_word.last = (i == 4);
				digest_expected = {digest_expected, exp_word};
			end
			sha1_reset_chain();
		end
	endtask

	// Offers one item, with random idle cycles ahead of it, and waits for acceptance.
	task automatic offer_item(input stim_row_t row);
		while (!quiet && $urandom_range(99) < 9) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		data_word <= row.word;
		byte_count <= row.count;
		last_word <= row.last;
		do @(posedge clk); while (data_stall);
		sha1_absorb(row);
		items_sent++;
		@(negedge clk);
	endtask

	// Digest receiver: random stalls, one long hold-off on request.
	initial begin
		bit hold_taken;
		digest_stall = 1'b0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				digest_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_taken = 1'b1;
			end
			digest_stall <= !quiet && ($urandom_range(99) < 9);
		end
	end

	// Compare each accepted digest word with the oldest expectation.
	always @(posedge clk) begin
		digest_exp_t exp_word;
		if (arst_n && digest_valid && !digest_stall) begin
			if (digest_expected.size() == 0) begin
				$error("unexpected digest word %h at index %0d", digest_word, word_index);
				mismatch_count++;
			end else begin
				exp_word = digest_expected.pop_front();
				if (digest_word !== exp_word.word) begin
					$error("digest_word: expected %h, got %h", exp_word.word, digest_word);
					mismatch_count++;
				end
				if (word_index !== exp_word.index) begin
					$error("word_index: expected %0d, got %0d", exp_word.index, word_index);
					mismatch_count++;
				end
				if (last_digest_word !== exp_word.last) begin
					$error("last_digest_word: expected %b, got %b", exp_word.last,
						last_digest_word);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((data_valid && !data_stall) || (digest_valid && !digest_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int body_len;
		bit hold_done;
		bit drain_done;
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		last_word = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		items_sent = 0;
		sha1_reset_chain();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows first.
		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_item(DIRECTED[i]);

		// Random messages, mostly shorter than two blocks, a few much longer.
		while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			if (!hold_done && items_sent >= 120) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && items_sent >= 250) begin
				data_valid <= 1'b0;
				do @(negedge clk); while (digest_expected.size() != 0);
				drain_done = 1'b1;
			end
			quiet = (items_sent >= 320 && items_sent < 400);
			body_len = ($urandom_range(9) == 0) ? $urandom_range(20, 70) :
				$urandom_range(0, 20);
			for (int w = 0; w < body_len; w++) begin
				row.word = $urandom;
				row.count = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'd4;
				row.last = 1'b0;
				row.known = 1'b0;
				row.digest = '0;
				offer_item(row);
			end
			row.word = $urandom;
			row.count = 3'($urandom_range(7));
			row.last = 1'b1;
			row.known = 1'b0;
			row.digest = '0;
			offer_item(row);
		end
		data_valid <= 1'b0;
		quiet = 1'b0;

		// Wait for the remaining digests, then watch for stray output.
		while (digest_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sha1_stream_hasher.f =====
src/sha1s_pkg.sv
src/sha1s_front.sv
src/sha1s_queue.sv
src/sha1s_back.sv
src/sha1_stream_hasher.sv
tb/sv/tb.sv
